/* src/pfcs_pkg.sv */
// ----------------------------------------------------------------------------
// pfcs_pkg
// Shared types, constants and the CRC-8 byte function for the pressure
// frame checker and scaler.
// ----------------------------------------------------------------------------
package pfcs_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [3:0] LAST_POS = 4'd8;

  // Pressure: round(|raw| * 64 / 15), sign applied afterwards.
  localparam logic [21:0] P_ROUND  = 22'd7;
  localparam logic [21:0] P_DIV    = 22'd15;
  localparam logic [22:0] P_RECIP  = 23'd4473924;  // floor(2^26 / 15)
  localparam int          P_SHIFT  = 26;

  // Temperature: (160 * raw + 8740800 + 62) / 125.
  localparam logic signed [24:0] T_GAIN   = 25'sd160;
  localparam logic signed [24:0] T_OFFSET = 25'sd8740862;
  localparam logic [23:0]        T_DIV    = 24'd125;
  localparam logic [24:0]        T_RECIP  = 25'd17179869; // floor(2^31 / 125)
  localparam int                 T_SHIFT  = 31;

  typedef struct packed {
    logic        err;
    logic [15:0] p_word;
    logic [15:0] t_word;
  } frame_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* src/pfcs_ifs.sv */
// ----------------------------------------------------------------------------
// pfcs_rx_if / pfcs_res_if
// Valid/ready channels: received sensor bytes in, scaled frame results out.
// ----------------------------------------------------------------------------
interface pfcs_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       first_byte;

  modport source (output valid, output rx_byte, output first_byte, input ready);
  modport sink   (input valid, input rx_byte, input first_byte, output ready);
endinterface

interface pfcs_res_if;
  logic               valid;
  logic               ready;
  logic               crc_error;
  logic signed [18:0] pressure_q8;
  logic        [16:0] temperature_q8;

  modport source (output valid, output crc_error, output pressure_q8,
                  output temperature_q8, input ready);
  modport sink   (input valid, input crc_error, input pressure_q8,
                  input temperature_q8, output ready);
endinterface

/* src/pfcs_framer.sv */
// ----------------------------------------------------------------------------
// pfcs_framer
// Registers each byte beat, tracks frame position, checks the three word
// CRCs and emits the raw words with the error flag after the ninth byte.
// ----------------------------------------------------------------------------
module pfcs_framer (
  input  logic            clk,
  input  logic            rst,
  pfcs_rx_if.sink         rx,
  output logic            frm_valid,
  input  logic            frm_ready,
  output pfcs_pkg::frame_t frm_data
);
  import pfcs_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_first;

  // frame state
  logic [3:0]  pos;
  logic [7:0]  crc;
  logic        err_seen;
  logic [7:0]  hold;
  logic [15:0] p_word;
  logic [15:0] t_word;

  logic [3:0]  pos_eff;
  logic [3:0]  pos_next;
  logic [7:0]  crc_next;
  logic        err_next;
  logic [7:0]  hold_next;
  logic [15:0] p_word_next;
  logic [15:0] t_word_next;
  logic        err_base;
  logic        done;
  logic        take;
  logic        frm_free;

  assign frm_free = !frm_valid || frm_ready;
  assign pos_eff  = (in_first || pos > LAST_POS) ? 4'd0 : pos;
  assign done     = (pos_eff == LAST_POS);
  assign take     = in_valid && (!done || frm_free);
  assign rx.ready = !in_valid || take;

  always_comb begin
    err_base    = (pos_eff == 4'd0) ? 1'b0 : err_seen;
    err_next    = err_base;
    crc_next    = crc;
    hold_next   = hold;
    p_word_next = p_word;
    t_word_next = t_word;
    pos_next    = done ? 4'd0 : pos_eff + 4'd1;
    case (pos_eff) inside
      4'd0, 4'd3, 4'd6: begin
        crc_next  = crc8_byte(CRC_INIT, in_byte);
        hold_next = in_byte;
      end
      4'd1, 4'd4, 4'd7: begin
        crc_next = crc8_byte(crc, in_byte);
        if (pos_eff == 4'd1) p_word_next = {hold, in_byte};
        if (pos_eff == 4'd4) t_word_next = {hold, in_byte};
      end
      default: begin
        if (crc != in_byte) err_next = 1'b1;
        crc_next = CRC_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
    if (rx.valid && rx.ready) begin
      in_byte  <= rx.rx_byte;
      in_first <= rx.first_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= 4'd0;
      crc      <= CRC_INIT;
      err_seen <= 1'b0;
    end else if (take) begin
      pos      <= pos_next;
      crc      <= crc_next;
      err_seen <= err_next;
    end
    if (take) begin
      hold   <= hold_next;
      p_word <= p_word_next;
      t_word <= t_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frm_valid <= 1'b0;
    end else if (frm_free) begin
      frm_valid <= take && done;
    end
    if (frm_free && take && done) begin
      frm_data.err    <= err_next;
      frm_data.p_word <= p_word;
      frm_data.t_word <= t_word;
    end
  end

endmodule

/* src/pfcs_scale.sv */
// ----------------------------------------------------------------------------
// pfcs_scale
// Converts the raw words to Q8 pressure and temperature: a reciprocal
// multiply stage, then a remainder correction stage into the result register.
// ----------------------------------------------------------------------------
module pfcs_scale (
  input  logic             clk,
  input  logic             rst,
  input  logic             frm_valid,
  output logic             frm_ready,
  input  pfcs_pkg::frame_t frm_data,
  pfcs_res_if.source       res
);
  import pfcs_pkg::*;

  // multiply stage
  logic        m_valid;
  logic        m_err;
  logic        m_neg;
  logic [21:0] m_p_num;
  logic [23:0] m_t_num;
  logic [44:0] m_p_prod;
  logic [48:0] m_t_prod;

  logic               p_neg;
  logic signed [16:0] p_ext;
  logic [16:0]        p_mag;
  logic [21:0]        p_num;
  logic signed [24:0] t_sum;
  logic [23:0]        t_num;

  logic [17:0] p_q0;
  logic [21:0] p_rem;
  logic [17:0] p_q;
  logic [18:0] p_s;
  logic [18:0] p_val;
  logic [16:0] t_q0;
  logic [23:0] t_rem;
  logic [16:0] t_q;

  logic out_free;
  logic m_free;

  assign out_free  = !res.valid || res.ready;
  assign m_free    = !m_valid || out_free;
  assign frm_ready = m_free;

  always_comb begin
    p_neg = frm_data.p_word[15];
    p_ext = 17'($signed(frm_data.p_word));
    p_mag = p_neg ? 17'(-p_ext) : 17'(p_ext);
    p_num = 22'({p_mag, 6'b0}) + P_ROUND;
    t_sum = 25'($signed(frm_data.t_word)) * T_GAIN + T_OFFSET;
    t_num = t_sum[23:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_free) begin
      m_valid <= frm_valid;
    end
    if (m_free && frm_valid) begin
      m_err    <= frm_data.err;
      m_neg    <= p_neg;
      m_p_num  <= p_num;
      m_t_num  <= t_num;
      m_p_prod <= 45'(p_num) * 45'(P_RECIP);
      m_t_prod <= 49'(t_num) * 49'(T_RECIP);
    end
  end

  always_comb begin
    p_q0  = m_p_prod[P_SHIFT +: 18];
    p_rem = m_p_num - 22'({p_q0, 4'b0}) + 22'(p_q0);
    p_q   = (p_rem >= P_DIV) ? p_q0 + 18'd1 : p_q0;
    p_s   = {1'b0, p_q};
    p_val = m_neg ? (~p_s + 19'd1) : p_s;
    t_q0  = m_t_prod[T_SHIFT +: 17];
    t_rem = m_t_num - 24'(t_q0) * T_DIV;
    t_q   = (t_rem >= T_DIV) ? t_q0 + 17'd1 : t_q0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_free) begin
      res.valid <= m_valid;
    end
    if (out_free && m_valid) begin
      res.crc_error      <= m_err;
      res.pressure_q8    <= m_err ? 19'sd0 : $signed(p_val);
      res.temperature_q8 <= m_err ? 17'd0 : t_q;
    end
  end

endmodule

/* src/pressure_frame_check_scale.sv */
// ----------------------------------------------------------------------------
// pressure_frame_check_scale
// Checks the word CRCs of a 9-byte differential pressure sensor reply and
// scales pressure and temperature to Q8.
// ----------------------------------------------------------------------------
// rx carries one reply byte per beat; first_byte restarts the frame at
// byte 0, otherwise the position counts on and wraps after byte 8.
// Each three-byte group (data high, data low, CRC-8 poly 0x31 init 0xFF)
// is checked. After the ninth byte one beat appears on result:
// crc_error, pressure_q8 = round(raw/60 * 256) and
// temperature_q8 = round((raw/200 + 273.15) * 256), both zero on error.
// Throughput is one byte per cycle while the receiver keeps up. The ninth
// byte passes the frame check into the frame register, then the reciprocal
// multiply stage, then remainder correction into the result register.
// Reset clears the frame position, the CRC and all valid flags. When the
// receiver stalls, the result register holds; the stages ahead of it keep
// taking bytes until two finished frames wait behind it and the ninth byte
// of the next frame sits in the input register.
// ----------------------------------------------------------------------------
module pressure_frame_check_scale (
  input  logic        clk,
  input  logic        rst,
  pfcs_rx_if.sink     rx,
  pfcs_res_if.source  result
);
  import pfcs_pkg::*;

  logic   frm_valid;
  logic   frm_ready;
  frame_t frm_data;

  pfcs_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm_data  (frm_data)
  );

  pfcs_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm_data  (frm_data),
    .res       (result)
  );

endmodule
